### design/xtt_pkg.sv
// ----------------------------------------------------------------------------
// xtt_pkg: shared types and constants of the xml tag line tokenizer
// Parse phases, character codes, field limits and the state and result records.
// ----------------------------------------------------------------------------
package xtt_pkg;

    localparam int CHAR_W  = 8;
    localparam int ROLE_W  = 2;
    localparam int CNT_W   = 4;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 3;
    localparam int PHASE_W = 4;

    localparam logic [POS_W-1:0] MAX_NAME_CHARS  = POS_W'(19);
    localparam logic [POS_W-1:0] MAX_FIELD_CHARS = POS_W'(29);
    localparam logic [CNT_W-1:0] MAX_ATTRS       = CNT_W'(10);

    // parse phases
    localparam logic [PHASE_W-1:0] PH_SKIP         = 4'd0;
    localparam logic [PHASE_W-1:0] PH_AFTER_LT     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_TAG_NAME     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ATTR_HEAD    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_ATTR_NAME    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_EXPECT_QUOTE = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ATTR_VALUE   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_EXPECT_SPACE = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DONE         = 4'd8;

    // roles
    localparam logic [ROLE_W-1:0] ROLE_MARKUP     = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_TAG_NAME   = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_ATTR_NAME  = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_ATTR_VALUE = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_LT      = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_QUOTE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW   = 3'd4;

    // characters
    localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               ending;
        logic [CNT_W-1:0]   attrs;
        logic [POS_W-1:0]   pos;
        logic [STAT_W-1:0]  err;
    } t_state;

    typedef struct packed {
        logic [ROLE_W-1:0] role;
        logic [CNT_W-1:0]  attr_index;
        logic [POS_W-1:0]  field_position;
        logic              tag_done;
        logic              is_ending;
        logic [CNT_W-1:0]  attr_count;
        logic [STAT_W-1:0] status;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:  PH_SKIP,
        ending: 1'b0,
        attrs:  '0,
        pos:    '0,
        err:    ST_OK
    };

endpackage

### design/xtt_if.sv
// ----------------------------------------------------------------------------
// xtt_if: character and token channels of the xml tag line tokenizer
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface xtt_in_if
    import xtt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;
    logic              line_end;

    modport source (output valid, output char_in, output line_end, input ready);
    modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface xtt_out_if
    import xtt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic [ROLE_W-1:0] role;
    logic [CNT_W-1:0]  attr_index;
    logic [POS_W-1:0]  field_position;
    logic              tag_done;
    logic              is_ending;
    logic [CNT_W-1:0]  attr_count;
    logic [STAT_W-1:0] status;
    logic              line_last;

    modport source (
        output valid, output char_out, output role, output attr_index,
        output field_position, output tag_done, output is_ending,
        output attr_count, output status, output line_last, input ready
    );
    modport sink (
        input valid, input char_out, input role, input attr_index,
        input field_position, input tag_done, input is_ending,
        input attr_count, input status, input line_last, output ready
    );
endinterface

### design/xtt_step.sv
// ----------------------------------------------------------------------------
// xtt_step: one-character parse step
// Labels the character from the current parse state and forms the next state.
// ----------------------------------------------------------------------------
module xtt_step
    import xtt_pkg::*;
(
    input  t_state             i_state,
    input  logic [CHAR_W-1:0]  i_char,
    input  logic               i_last,
    output t_state             o_state,
    output t_result            o_result
);

    always_comb begin
        t_state            s;
        logic              taken;
        logic              fin;
        logic [ROLE_W-1:0] role;
        logic [CNT_W-1:0]  idx;
        logic [POS_W-1:0]  pos;

        s     = i_state;
        taken = 1'b0;
        fin   = 1'b0;
        role  = ROLE_MARKUP;
        idx   = '0;
        pos   = '0;

        if (s.phase == PH_SKIP) begin
            taken = 1'b1;
            if (i_char == CH_LT) begin
                s.phase = PH_AFTER_LT;
            end else if (i_char != CH_SPACE) begin
                s.err = ST_NO_LT; s.phase = PH_DONE; fin = 1'b1;
            end
        end

        // a non-slash after '<' is the first tag name character
        if (!taken && s.phase == PH_AFTER_LT) begin
            s.phase = PH_TAG_NAME;
            s.pos   = '0;
            if (i_char == CH_SLASH) begin
                s.ending = 1'b1;
                taken    = 1'b1;
            end
        end

        if (!taken && s.phase == PH_TAG_NAME) begin
            taken = 1'b1;
            if (i_char == CH_SPACE) begin
                if (s.ending) begin
                    s.err = ST_OK; s.phase = PH_DONE; fin = 1'b1;
                end else begin
                    s.phase = PH_ATTR_HEAD;
                end
            end else if (i_char == CH_GT) begin
                s.err = ST_OK; s.phase = PH_DONE; fin = 1'b1;
            end else if (s.pos >= MAX_NAME_CHARS) begin
                s.err = ST_OVERFLOW; s.phase = PH_DONE; fin = 1'b1;
            end else begin
                role  = ROLE_TAG_NAME;
                pos   = s.pos;
                s.pos = s.pos + POS_W'(1);
            end
        end

        // any other head character opens an attribute name, unless MAX_ATTRS are already counted
        if (!taken && s.phase == PH_ATTR_HEAD) begin
            if (i_char == CH_SLASH) begin
                taken = 1'b1; s.ending = 1'b1;
                s.err = ST_OK; s.phase = PH_DONE; fin = 1'b1;
            end else if (i_char == CH_GT) begin
                taken = 1'b1; s.ending = 1'b0;
                s.err = ST_OK; s.phase = PH_DONE; fin = 1'b1;
            end else if (s.attrs >= MAX_ATTRS) begin
                taken = 1'b1;
                s.err = ST_OVERFLOW; s.phase = PH_DONE; fin = 1'b1;
            end else begin
                s.phase = PH_ATTR_NAME;
                s.pos   = '0;
            end
        end

        if (!taken && s.phase == PH_ATTR_NAME) begin
            taken = 1'b1;
            if (i_char == CH_EQ) begin
                s.phase = PH_EXPECT_QUOTE;
            end else if (s.pos >= MAX_FIELD_CHARS) begin
                s.err = ST_OVERFLOW; s.phase = PH_DONE; fin = 1'b1;
            end else begin
                role  = ROLE_ATTR_NAME;
                idx   = s.attrs;
                pos   = s.pos;
                s.pos = s.pos + POS_W'(1);
            end
        end

        if (!taken && s.phase == PH_EXPECT_QUOTE) begin
            taken = 1'b1;
            if (i_char == CH_QUOTE) begin
                s.phase = PH_ATTR_VALUE;
                s.pos   = '0;
            end else begin
                s.err = ST_NO_QUOTE; s.phase = PH_DONE; fin = 1'b1;
            end
        end

        if (!taken && s.phase == PH_ATTR_VALUE) begin
            taken = 1'b1;
            if (i_char == CH_QUOTE) begin
                s.attrs = s.attrs + CNT_W'(1);
                s.phase = PH_EXPECT_SPACE;
            end else if (s.pos >= MAX_FIELD_CHARS) begin
                s.err = ST_OVERFLOW; s.phase = PH_DONE; fin = 1'b1;
            end else begin
                role  = ROLE_ATTR_VALUE;
                idx   = s.attrs;
                pos   = s.pos;
                s.pos = s.pos + POS_W'(1);
            end
        end

        if (!taken && s.phase == PH_EXPECT_SPACE) begin
            if (i_char == CH_SPACE) begin
                s.phase = PH_ATTR_HEAD;
            end else begin
                s.err = ST_NO_SPACE; s.phase = PH_DONE; fin = 1'b1;
            end
        end

        // line end closes an open tag
        if (i_last && s.phase != PH_DONE) begin
            if (s.phase == PH_SKIP) begin
                s.err = ST_NO_LT;
            end else if (s.phase == PH_ATTR_NAME || s.phase == PH_EXPECT_QUOTE ||
                         s.phase == PH_ATTR_VALUE) begin
                s.err = ST_NO_QUOTE;
            end else begin
                s.err = ST_OK;
            end
            s.phase = PH_DONE;
            fin     = 1'b1;
        end

        o_result.role           = role;
        o_result.attr_index     = idx;
        o_result.field_position = pos;
        o_result.tag_done       = fin;
        o_result.is_ending      = fin & s.ending;
        o_result.attr_count     = s.attrs;
        o_result.status         = s.err;

        o_state = i_last ? STATE_RESET : s;
    end

endmodule

### design/xml_tag_line_tokenizer_core.sv
// ----------------------------------------------------------------------------
// xml_tag_line_tokenizer_core: character-serial xml tag tokenizer
// Labels each character of a one-line tag by role, with field position,
// attribute index, completion and status.
// ----------------------------------------------------------------------------
// One word in gives one word out, one word per cycle sustained while the
// output is ready. A character passes an input register, then the parse step,
// then the output register. The parse state updates as the character leaves
// the input register, so the next character may follow at once; while a
// finished result waits, the input side accepts only until the input
// register is full. The parse state returns to reset after each word
// marked with line_end.
module xml_tag_line_tokenizer_core
    import xtt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    xtt_in_if.sink     i_in,
    xtt_out_if.source  o_out
);

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    t_result           r_out_res;

    t_state            r_state;
    t_state            n_state;
    t_result           n_res;

    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    xtt_step u_step (
        .i_state  (r_state),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.char_in;
            r_in_last <= i_in.line_end;
        end
        if (advance) begin
            r_out_char <= r_in_char;
            r_out_last <= r_in_last;
            r_out_res  <= n_res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.char_out       = r_out_char;
    assign o_out.role           = r_out_res.role;
    assign o_out.attr_index     = r_out_res.attr_index;
    assign o_out.field_position = r_out_res.field_position;
    assign o_out.tag_done       = r_out_res.tag_done;
    assign o_out.is_ending      = r_out_res.is_ending;
    assign o_out.attr_count     = r_out_res.attr_count;
    assign o_out.status         = r_out_res.status;
    assign o_out.line_last      = r_out_last;

endmodule
